[design/fla_pkg.sv]
package fla_pkg;

	localparam int unsigned HEAP_WORDS = 4096;
	localparam int unsigned IDX_W      = $clog2(HEAP_WORDS);
	localparam int unsigned VISIT_MAX  = HEAP_WORDS / 4;
	localparam int unsigned VISIT_W    = $clog2(VISIT_MAX + 2);
	localparam int unsigned CAP_RAW    = (HEAP_WORDS * 8 > 32768) ? 32768 : HEAP_WORDS * 8;
	localparam int unsigned CAP_BYTES  = CAP_RAW - (CAP_RAW % 16);

	localparam logic [63:0] SIZE_MASK = ~64'hF;
	localparam logic [63:0] ALLOC_BIT = 64'h1;
	localparam logic [63:0] MIN_BLOCK = 64'd32;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_FORMAT = 2'd2;

	typedef struct packed {
		logic        en;
		logic        we;
		logic [63:0] addr;
		logic [63:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic        valid;
		logic        ok;
		logic [14:0] payload_offset;
	} done_t;

endpackage

[design/fla_if.sv]
interface fla_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] request_size;
	logic [14:0] free_offset;

	modport source (output valid, opcode, request_size, free_offset, input ready);
	modport sink (input valid, opcode, request_size, free_offset, output ready);
endinterface

interface fla_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [14:0] payload_offset;

	modport source (output valid, ok, payload_offset, input ready);
	modport sink (input valid, ok, payload_offset, output ready);
endinterface

[design/fla_heap_ram.sv]
module fla_heap_ram (
	input  logic               clk,
	input  logic               arst_n,
	input  fla_pkg::mem_req_t  req,
	output logic [63:0]        rdata
);
	logic [63:0] mem [fla_pkg::HEAP_WORDS];
	logic [63:0] rd_q;
	logic        hit_q;
	logic        in_range;
	logic [fla_pkg::IDX_W-1:0] idx;

	// byte address; words past the end read as zero and drop writes
	assign in_range = (req.addr >> 3) < 64'(fla_pkg::HEAP_WORDS);
	assign idx      = req.addr[3 +: fla_pkg::IDX_W];

	always_ff @(posedge clk) begin
		if (req.en && req.we && in_range) begin
			mem[idx] <= req.wdata;
		end
		if (req.en && !req.we) begin
			rd_q <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (req.en && !req.we) begin
			hit_q <= in_range;
		end
	end

	assign rdata = hit_q ? rd_q : 64'd0;
endmodule

[design/fla_ctrl.sv]
module fla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         opcode,
	input  logic [15:0]        request_size,
	input  logic [14:0]        free_offset,
	input  logic [15:0]        heap_len,
	input  logic               slot_free,
	input  logic [63:0]        rdata,
	output logic               idle,
	output fla_pkg::mem_req_t  mreq,
	output fla_pkg::done_t     done
);
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_FIN  = 5'd1;
	localparam logic [4:0] S_FMT  = 5'd2;
	localparam logic [4:0] S_ACHK = 5'd3;
	localparam logic [4:0] S_ASZ  = 5'd4;
	localparam logic [4:0] S_ANX  = 5'd5;
	localparam logic [4:0] S_ASPL = 5'd6;
	localparam logic [4:0] S_F0   = 5'd7;
	localparam logic [4:0] S_F1   = 5'd8;
	localparam logic [4:0] S_F2   = 5'd9;
	localparam logic [4:0] S_F3   = 5'd10;
	localparam logic [4:0] S_F4   = 5'd11;
	localparam logic [4:0] S_FP1  = 5'd12;
	localparam logic [4:0] S_FP2  = 5'd13;
	localparam logic [4:0] S_FP3  = 5'd14;
	localparam logic [4:0] S_TAG1 = 5'd15;
	localparam logic [4:0] S_TAG2 = 5'd16;
	localparam logic [4:0] S_L0   = 5'd17;
	localparam logic [4:0] S_L1   = 5'd18;
	localparam logic [4:0] S_L2   = 5'd19;
	localparam logic [4:0] S_L3   = 5'd20;
	localparam logic [4:0] S_L4   = 5'd21;
	localparam logic [4:0] S_L5   = 5'd22;
	localparam logic [4:0] S_L6   = 5'd23;

	logic [4:0]  state_q, t_ret_q;
	logic [63:0] p_q, sz_q, need_q, t_bp_q, t_v_q, l_old_q, l_new_q;
	logic [63:0] nx_q, pv_q, prev_bp_q, next_bp_q, prev_sz_q;
	logic        l_swap_q, res_ok_q;
	logic [14:0] res_off_q;
	logic [15:0] head_q;
	logic [2:0]  fmt_q;
	logic [fla_pkg::VISIT_W-1:0] visits_q;

	logic [15:0] hs_m, hs;
	logic [63:0] hs64, rsz, avail_c, prev_bp_c, next_sz_c, size_in, need_c;
	logic        fits_c, whole_c;

	// clamp the formatted length to [64, capacity], 16-byte granular
	always_comb begin
		hs_m = heap_len & 16'hFFF0;
		if (hs_m < 16'd64) begin
			hs = 16'd64;
		end else if (32'(hs_m) > fla_pkg::CAP_BYTES) begin
			hs = 16'(fla_pkg::CAP_BYTES);
		end else begin
			hs = hs_m;
		end
	end
	assign hs64 = 64'(hs);

	assign size_in   = 64'(request_size);
	assign need_c    = ((size_in > 64'd16 ? size_in : 64'd16) + 64'd31) & fla_pkg::SIZE_MASK;
	assign rsz       = rdata & fla_pkg::SIZE_MASK;
	assign avail_c   = rsz;
	assign fits_c    = avail_c >= need_q;
	assign whole_c   = (avail_c - need_q) < fla_pkg::MIN_BLOCK;
	assign prev_bp_c = p_q - rsz;
	assign next_sz_c = rsz;

	assign idle = state_q == S_IDLE;

	always_comb begin
		mreq = '0;
		case (state_q)
			S_FMT: begin
				mreq.en = 1'b1;
				mreq.we = 1'b1;
				case (fmt_q)
					3'd0: begin mreq.addr = 64'd0;         mreq.wdata = 64'd0; end
					3'd1: begin mreq.addr = 64'd8;         mreq.wdata = 64'd17; end
					3'd2: begin mreq.addr = 64'd16;        mreq.wdata = 64'd17; end
					3'd3: begin mreq.addr = 64'd24;        mreq.wdata = hs64 - 64'd32; end
					3'd4: begin mreq.addr = hs64 - 64'd16; mreq.wdata = hs64 - 64'd32; end
					3'd5: begin mreq.addr = 64'd32;        mreq.wdata = 64'd0; end
					3'd6: begin mreq.addr = 64'd40;        mreq.wdata = 64'd0; end
					default: begin mreq.addr = hs64 - 64'd8; mreq.wdata = fla_pkg::ALLOC_BIT; end
				endcase
			end
			S_ACHK: begin
				mreq.en   = 1'b1;
				mreq.addr = p_q - 64'd8;
			end
			S_ASZ: begin
				mreq.en   = !fits_c;
				mreq.addr = p_q;
			end
			S_F0: begin
				mreq.en   = 1'b1;
				mreq.addr = p_q - 64'd8;
			end
			S_F1: begin
				mreq.en   = 1'b1;
				mreq.addr = p_q - 64'd16;
			end
			S_F2: begin
				mreq.en   = 1'b1;
				mreq.addr = prev_bp_c - 64'd8;
			end
			S_F3: begin
				mreq.en   = 1'b1;
				mreq.addr = next_bp_q - 64'd8;
			end
			S_FP1: begin
				mreq.en    = 1'b1;
				mreq.we    = 1'b1;
				mreq.addr  = p_q;
				mreq.wdata = 64'(head_q);
			end
			S_FP2: begin
				mreq.en    = 1'b1;
				mreq.we    = 1'b1;
				mreq.addr  = p_q + 64'd8;
				mreq.wdata = 64'd0;
			end
			S_FP3: begin
				mreq.en    = head_q != 16'd0;
				mreq.we    = 1'b1;
				mreq.addr  = 64'(head_q) + 64'd8;
				mreq.wdata = p_q;
			end
			S_TAG1: begin
				mreq.en    = 1'b1;
				mreq.we    = 1'b1;
				mreq.addr  = t_bp_q - 64'd8;
				mreq.wdata = t_v_q;
			end
			S_TAG2: begin
				mreq.en    = 1'b1;
				mreq.we    = 1'b1;
				mreq.addr  = t_bp_q + (t_v_q & fla_pkg::SIZE_MASK) - 64'd16;
				mreq.wdata = t_v_q;
			end
			S_L0: begin
				mreq.en   = 1'b1;
				mreq.addr = l_old_q;
			end
			S_L1: begin
				mreq.en   = 1'b1;
				mreq.addr = l_old_q + 64'd8;
			end
			S_L3: begin
				mreq.en    = 1'b1;
				mreq.we    = 1'b1;
				mreq.addr  = l_new_q;
				mreq.wdata = nx_q;
			end
			S_L4: begin
				mreq.en    = 1'b1;
				mreq.we    = 1'b1;
				mreq.addr  = l_new_q + 64'd8;
				mreq.wdata = pv_q;
			end
			S_L5: begin
				mreq.en    = nx_q != 64'd0;
				mreq.we    = 1'b1;
				mreq.addr  = nx_q + 64'd8;
				mreq.wdata = l_swap_q ? l_new_q : pv_q;
			end
			S_L6: begin
				mreq.en    = pv_q != 64'd0;
				mreq.we    = 1'b1;
				mreq.addr  = pv_q;
				mreq.wdata = l_swap_q ? l_new_q : nx_q;
			end
			default: mreq = '0;
		endcase
	end

	assign done.valid          = (state_q == S_FIN) && slot_free;
	assign done.ok             = res_ok_q;
	assign done.payload_offset = res_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= 16'd0;
			t_ret_q  <= S_IDLE;
			fmt_q    <= 3'd0;
			visits_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (opcode)
							fla_pkg::OP_ALLOC:  state_q <= S_ACHK;
							fla_pkg::OP_FREE:   state_q <= S_F0;
							fla_pkg::OP_FORMAT: state_q <= S_FMT;
							default:            state_q <= S_FIN;
						endcase
						visits_q <= '0;
						fmt_q    <= 3'd0;
					end
				end
				S_FMT: begin
					fmt_q <= fmt_q + 3'd1;
					if (fmt_q == 3'd7) begin
						head_q  <= 16'd32;
						state_q <= S_FIN;
					end
				end
				S_ACHK: begin
					if (p_q == 64'd0 || 32'(visits_q) > fla_pkg::VISIT_MAX) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_ASZ;
					end
				end
				S_ASZ: begin
					if (!fits_c) begin
						state_q <= S_ANX;
					end else begin
						state_q <= S_TAG1;
						t_ret_q <= whole_c ? S_L0 : S_ASPL;
					end
				end
				S_ANX: begin
					visits_q <= visits_q + 1'b1;
					state_q  <= S_ACHK;
				end
				S_ASPL: begin
					state_q <= S_TAG1;
					t_ret_q <= S_L0;
				end
				S_F0: state_q <= S_F1;
				S_F1: state_q <= S_F2;
				S_F2: state_q <= S_F3;
				S_F3: state_q <= S_F4;
				S_F4: begin
					state_q <= S_TAG1;
					if (prev_sz_q[0] && rdata[0]) begin
						t_ret_q <= S_FP1;
					end else if (prev_sz_q[0]) begin
						t_ret_q <= S_L0;
					end else if (rdata[0]) begin
						t_ret_q <= S_FIN;
					end else begin
						t_ret_q <= S_L0;
					end
				end
				S_FP1: state_q <= S_FP2;
				S_FP2: state_q <= S_FP3;
				S_FP3: begin
					head_q  <= p_q[15:0];
					state_q <= S_FIN;
				end
				S_TAG1: state_q <= S_TAG2;
				S_TAG2: state_q <= t_ret_q;
				S_L0: state_q <= S_L1;
				S_L1: state_q <= S_L2;
				S_L2: begin
					if (64'(head_q) == l_old_q) begin
						head_q <= l_swap_q ? l_new_q[15:0] : nx_q[15:0];
					end
					state_q <= l_swap_q ? S_L3 : S_L5;
				end
				S_L3: state_q <= S_L4;
				S_L4: state_q <= S_L5;
				S_L5: state_q <= S_L6;
				S_L6: state_q <= S_FIN;
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ok_q  <= 1'b0;
			res_off_q <= 15'd0;
			l_swap_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						res_ok_q  <= (opcode == fla_pkg::OP_FREE) ||
							(opcode == fla_pkg::OP_FORMAT);
						res_off_q <= 15'd0;
						need_q    <= need_c;
						p_q       <= (opcode == fla_pkg::OP_ALLOC) ? 64'(head_q) :
							64'(free_offset);
					end
				end
				S_ASZ: begin
					sz_q <= avail_c;
					if (fits_c) begin
						res_ok_q  <= 1'b1;
						res_off_q <= p_q[14:0];
						t_bp_q    <= p_q;
						t_v_q     <= (whole_c ? avail_c : need_q) | fla_pkg::ALLOC_BIT;
						l_old_q   <= p_q;
						l_new_q   <= p_q + need_q;
						l_swap_q  <= !whole_c;
					end
				end
				S_ANX: p_q <= rdata;
				S_ASPL: begin
					t_bp_q <= l_new_q;
					t_v_q  <= sz_q - need_q;
				end
				S_F1: sz_q <= rsz;
				S_F2: begin
					prev_bp_q <= prev_bp_c;
					next_bp_q <= p_q + sz_q;
				end
				S_F3: prev_sz_q <= rdata;
				S_F4: begin
					if (prev_sz_q[0] && rdata[0]) begin
						t_bp_q <= p_q;
						t_v_q  <= sz_q;
					end else if (prev_sz_q[0]) begin
						// merge with next: this block takes its list place
						t_bp_q   <= p_q;
						t_v_q    <= sz_q + next_sz_c;
						l_old_q  <= next_bp_q;
						l_new_q  <= p_q;
						l_swap_q <= 1'b1;
					end else if (rdata[0]) begin
						t_bp_q <= prev_bp_q;
						t_v_q  <= sz_q + (prev_sz_q & fla_pkg::SIZE_MASK);
					end else begin
						t_bp_q   <= prev_bp_q;
						t_v_q    <= sz_q + next_sz_c + (prev_sz_q & fla_pkg::SIZE_MASK);
						l_old_q  <= next_bp_q;
						l_swap_q <= 1'b0;
					end
				end
				S_L1: nx_q <= rdata;
				S_L2: pv_q <= rdata;
				default: ;
			endcase
		end
	end
endmodule

[design/free_list_heap_allocator.sv]
// First-fit heap allocator with an explicit doubly linked free list. All heap
// state (boundary tags and list links) lives in one 4096 x 64 single-port RAM
// with registered reads, so every request is a sequence of single RAM
// accesses. A free runs longer or shorter depending on which neighbours
// merge, an allocate runs longer for each free block passed over and longer
// when the taken block is split than when it is taken whole, and a failed
// allocate runs longer for each visited block. Only one request is in
// flight; the next one can be accepted in the same cycle that the previous
// result first sits in the output register. Issue a format (opcode 2)
// before any allocate or free; the configured heap length is sampled when the
// format runs.
module free_list_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	fla_req_if.sink     req,
	fla_rsp_if.source   rsp
);
	logic [15:0]       heap_len_q;
	logic              rsp_valid_q, rsp_ok_q, idle, slot_free;
	logic [14:0]       rsp_off_q;
	logic [63:0]       rdata;
	fla_pkg::mem_req_t mreq;
	fla_pkg::done_t    done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_len_q <= 16'd32768;
		end else if (cfg_we) begin
			heap_len_q <= cfg_wdata;
		end
	end

	assign req.ready = idle;
	assign slot_free = !rsp_valid_q || rsp.ready;

	fla_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (req.valid && idle),
		.opcode       (req.opcode),
		.request_size (req.request_size),
		.free_offset  (req.free_offset),
		.heap_len     (heap_len_q),
		.slot_free    (slot_free),
		.rdata        (rdata),
		.idle         (idle),
		.mreq         (mreq),
		.done         (done)
	);

	fla_heap_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (rdata)
	);

	// output register: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_ok_q    <= 1'b0;
			rsp_off_q   <= 15'd0;
		end else if (done.valid) begin
			rsp_valid_q <= 1'b1;
			rsp_ok_q    <= done.ok;
			rsp_off_q   <= done.payload_offset;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.ok             = rsp_ok_q;
	assign rsp.payload_offset = rsp_off_q;
endmodule

[design/fla_checker.sv]
module fla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_ok,
	input logic [14:0] rsp_payload_offset
);
	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_payload_offset))
		else $error("result beat changed while stalled");

	a_off_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload_offset != 15'd0 |-> rsp_ok)
		else $error("nonzero offset on a failed result");

	// a request never answers in the cycle right after it is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared too early");

	// once a result is posted the block is free for the next request
	a_ready_after: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("not ready after posting a result");
endmodule

bind free_list_heap_allocator fla_checker u_fla_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_ok             (rsp.ok),
	.rsp_payload_offset (rsp.payload_offset)
);
